/* src/mipmap_box_downsample_top_macros.svh */
// Assertion macros for the mipmap box downsampler.
// Used by mipmap_box_downsample_top; no other dependencies.
`ifndef MIPMAP_BOX_DOWNSAMPLE_TOP_MACROS_SVH
`define MIPMAP_BOX_DOWNSAMPLE_TOP_MACROS_SVH

// Check that cond_b holds in the same cycle whenever cond_a holds
`define MBD_ASSERT_NOW(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
      else $error("mipmap downsampler check failed");

// Check that cond_b holds in the cycle after cond_a holds
`define MBD_ASSERT_NEXT(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
      else $error("mipmap downsampler check failed");

`endif

/* src/mbd_pkg.sv */
// Shared constants, types and lane arithmetic for the mipmap box downsampler.
// No dependencies; imported by mipmap_box_downsample_top.
package mbd_pkg;

   // Geometry limits
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);

   // Field widths
   localparam int DIM_W     = 13;
   localparam int PIX_W     = 32;
   localparam int CHAN_W    = 8;
   localparam int LANE_W    = 9;
   localparam int NUM_LANES = 4;
   localparam int SUM_W     = NUM_LANES * LANE_W;
   localparam int CSR_IDX_W = 1;

   // Register reset values
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(256);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOURCE_WIDTH  = 1'b0,
      REG_SOURCE_HEIGHT = 1'b1
   } csr_reg_type;

   typedef logic [SUM_W-1:0] lane_sum_type;

   // Spread ARGB8888 into four 9-bit lanes with a guard bit each
   function automatic lane_sum_type spread(input logic [PIX_W-1:0] p);
      lane_sum_type v;
      v = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         v[i*LANE_W +: LANE_W] = {1'b0, p[i*CHAN_W +: CHAN_W]};
      end
      return v;
   endfunction

   // Clamp a dimension to 1..hi
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > hi) begin
         r = DIM_W'(hi);
      end
      return r;
   endfunction

   // Average two pair sums: (upper + lower) >> 2 per lane
   function automatic logic [PIX_W-1:0] avg_blocks(input lane_sum_type a, input lane_sum_type b);
      logic [PIX_W-1:0] r;
      logic [LANE_W:0]  s;
      r = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         s = {1'b0, a[i*LANE_W +: LANE_W]} + {1'b0, b[i*LANE_W +: LANE_W]};
         r[i*CHAN_W +: CHAN_W] = s[LANE_W:2];
      end
      return r;
   endfunction

   // Single-row level: the pair counts twice, so halve each lane
   function automatic logic [PIX_W-1:0] half_pair(input lane_sum_type a);
      logic [PIX_W-1:0] r;
      r = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         r[i*CHAN_W +: CHAN_W] = a[i*LANE_W+1 +: CHAN_W];
      end
      return r;
   endfunction

endpackage

/* src/mipmap_box_downsample_top.sv */
// Mipmap 2x2 box-filter downsampler: one source level in, the next level out.
// Depends on mbd_pkg and mipmap_box_downsample_top_macros.svh.
//
// Usage:
//   req_*  : source ARGB8888 pixels in raster order, valid/ready.
//   rsp_*  : averaged pixels of the next level with row and level end
//            flags, valid/ready. Output is floor(W/2) x floor(H/2); a source
//            dimension of 1 gives an output dimension of 1.
//   csr_*  : write-only port; index 0 source width, index 1 source height.
//            Any write restarts the level at its first pixel. Write only
//            while the block is idle.
// Throughput: one pixel per cycle unless the output stalls, set by the at most one
// column-sum store access per pixel pair (one write in even rows, one read in odd).
// Pipeline: the store read and stage 1 are registered at the edge that accepts the
// last source pixel of a result, and the output register follows them.
// Reset: counters clear, dimensions return to 256 x 256. The column-sum store
// is not cleared; each entry is written in an even row before it is read.
// Stall: while rsp_ready is low the output register and the pipeline stage
// behind it hold; req_ready drops only once both are full.
module mipmap_box_downsample_top
   import mbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] req_src_pixel,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_dst_pixel,
   output logic             rsp_row_end,
   output logic             rsp_frame_end,
   input  logic             csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

`include "mipmap_box_downsample_top_macros.svh"

   // Configuration and position state
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   lane_sum_type     pair_ff, pair_in;
   logic             restart;

   // Column-sum store
   lane_sum_type     column_sums [STORE_DEPTH];
   lane_sum_type     rd_data_ff;

   // Stage 1 (store read in flight) and output register
   logic             s1_valid_ff, s1_valid_in;
   lane_sum_type     s1_pair_ff;
   logic             s1_half_ff;
   logic             s1_row_end_ff;
   logic             s1_frame_end_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_row_end_ff;
   logic             rsp_frame_end_ff;

   // Per-pixel decode
   logic             advance;
   logic             accept;
   logic             w_one;
   logic             h_one;
   lane_sum_type     px;
   lane_sum_type     pair;
   logic             pair_done;
   logic             row_odd;
   logic [ADDR_W-1:0] ox;
   logic [ROW_W-2:0] oy;
   logic [DIM_W-1:0] out_w;
   logic [DIM_W-1:0] out_h;
   logic             last_col;
   logic             last_row;
   logic             mem_wr;
   logic             mem_rd;
   logic             emit;
   logic             row_end;
   logic             frame_end;
   logic             col_in_range;
   logic             row_in_range;

   // Handshake: the pipeline moves when the output register frees up
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // Decode the position of the incoming pixel
   assign w_one     = (width_ff == DIM_W'(1));
   assign h_one     = (height_ff == DIM_W'(1));
   assign px        = spread(req_src_pixel);
   assign pair_done = w_one || col_ff[0];
   assign pair      = w_one ? (px + px) : (pair_ff + px);
   assign row_odd   = row_ff[0];
   assign ox        = w_one ? '0 : col_ff[COL_W-1:1];
   assign oy        = h_one ? '0 : row_ff[ROW_W-1:1];
   assign out_w     = w_one ? DIM_W'(1) : (width_ff >> 1);
   assign out_h     = h_one ? DIM_W'(1) : (height_ff >> 1);
   assign last_col  = (32'(col_ff) + 32'd1) >= 32'(width_ff);
   assign last_row  = (32'(row_ff) + 32'd1) >= 32'(height_ff);
   assign row_end   = (32'(ox) + 32'd1) >= 32'(out_w);
   assign frame_end = row_end && ((32'(oy) + 32'd1) >= 32'(out_h));

   // Even rows store the pair, odd rows read the pair above
   assign mem_wr = accept && pair_done && !h_one && !row_odd;
   assign mem_rd = accept && pair_done && !h_one && row_odd;
   assign emit   = accept && pair_done && (h_one || row_odd);

   // Configuration writes and position counters
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pair_in   = pair_ff;
      restart   = 1'b0;
      if (accept) begin
         if (!pair_done) begin
            pair_in = px;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      if (csr_wr_en) begin
         restart = 1'b1;
         case (csr_reg_type'(csr_index))
            REG_SOURCE_WIDTH: begin
               width_in = clamp_dim(csr_wdata, MAX_WIDTH);
            end
            REG_SOURCE_HEIGHT: begin
               height_in = clamp_dim(csr_wdata, MAX_HEIGHT);
            end
            default: begin
               restart = 1'b0;
            end
         endcase
         if (restart) begin
            col_in  = '0;
            row_in  = '0;
            pair_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         pair_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pair_ff   <= pair_in;
      end
   end

   // Column-sum store: at most one write or one registered read per pixel pair
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         column_sums[ox] <= pair;
      end
      if (mem_rd) begin
         rd_data_ff <= column_sums[ox];
      end
   end

   // Stage 1: hold the lower pair while the upper pair is read
   assign s1_valid_in = req_ready ? emit : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_pair_ff      <= pair;
         s1_half_ff      <= h_one;
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
      end
   end

   // Output register: average and present the item
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_pixel_ff     <= s1_half_ff ? half_pair(s1_pair_ff)
                                        : avg_blocks(rd_data_ff, s1_pair_ff);
         rsp_row_end_ff   <= s1_row_end_ff;
         rsp_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dst_pixel = rsp_pixel_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // Position always stays inside the configured level
   assign col_in_range = (32'(col_ff) < 32'(width_ff));
   assign row_in_range = (32'(row_ff) < 32'(height_ff));

   `MBD_ASSERT_NOW(a_col_in_range, clock, reset, 1'b1, col_in_range && row_in_range)
   `MBD_ASSERT_NOW(a_frame_end_on_row_end, clock, reset, rsp_valid_ff && rsp_frame_end_ff, rsp_row_end_ff)
   `MBD_ASSERT_NEXT(a_stage1_holds, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_pair_ff))

endmodule

/* tb/tb.sv */
// Self-checking testbench for mipmap_box_downsample_top: 2x2 box-filter downsampling
// checked against an in-bench pixel predictor, with directed rows and random levels.
// Depends on mbd_pkg and the RTL of mipmap_box_downsample_top only.
module tb;
   import mbd_pkg::*;

   typedef logic [NUM_LANES-1:0][LANE_W-1:0] lane_quad_type;

   typedef struct packed {
      logic [PIX_W-1:0] dst_pixel;
      logic             row_end;
      logic             frame_end;
   } mip_px_type;

   typedef struct packed {
      bit               is_csr;
      csr_reg_type      reg_sel;
      logic [DIM_W-1:0] dim;
      logic [PIX_W-1:0] pixel;
      bit               typed;
      logic [PIX_W-1:0] want_pixel;
      bit               want_row_end;
      bit               want_frame_end;
   } stim_row_type;

   // Directed rows: register writes and pixels, expected result typed in where obvious
   localparam stim_row_type DIR_ROWS [30] = '{
      '{1'b1, REG_SOURCE_WIDTH,  13'd2,    32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b1, REG_SOURCE_HEIGHT, 13'd2,    32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'hFFFFFFFF, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'hFFFFFFFF, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'hFFFFFFFF, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b1},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h00000000, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h00000000, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h00000000, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h00000000, 1'b1, 32'h00000000, 1'b1, 1'b1},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h12345678, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b1, REG_SOURCE_WIDTH,  13'd1,    32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h01020304, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h03040506, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b1, REG_SOURCE_WIDTH,  13'd0,    32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b1, REG_SOURCE_HEIGHT, 13'd1,    32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'hA5C30F81, 1'b1, 32'hA5C30F81, 1'b1, 1'b1},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b1},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h00000000, 1'b1, 32'h00000000, 1'b1, 1'b1},
      '{1'b1, REG_SOURCE_WIDTH,  13'd3,    32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b1, REG_SOURCE_HEIGHT, 13'd3,    32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h80FF0001, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h7F00FFFE, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'hDEADBEEF, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h01010101, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'hFEFEFEFE, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h00FF00FF, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'hFF00FF00, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h13579BDF, 1'b0, 32'h0,        1'b0, 1'b0},
      '{1'b0, REG_SOURCE_WIDTH,  13'd0,    32'h2468ACE0, 1'b0, 32'h0,        1'b0, 1'b0}
   };

   localparam int RANDOM_PIXELS = 820;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [PIX_W-1:0] req_src_pixel = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_dst_pixel;
   logic             rsp_row_end;
   logic             rsp_frame_end;
   logic             csr_wr_en = 1'b0;
   csr_reg_type      csr_index = REG_SOURCE_WIDTH;
   logic [DIM_W-1:0] csr_wdata = '0;

   // Predictor state
   lane_quad_type    col_store [STORE_DEPTH];
   lane_quad_type    pair_acc;
   int unsigned      col_pos;
   int unsigned      row_pos;
   logic [DIM_W-1:0] width_cfg;
   logic [DIM_W-1:0] height_cfg;

   mip_px_type pending_px [$];
   int      err_count;
   int      results_checked;
   int      pixels_in;
   int      levels_run;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_left;

   mipmap_box_downsample_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_src_pixel (req_src_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_dst_pixel (rsp_dst_pixel),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Give up after a generous bound
   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // Effective dimension: zero counts as one, anything above the limit as the limit
   function automatic int unsigned dim_eff(input logic [DIM_W-1:0] v, input int unsigned hi);
      if (v == '0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Advance the predictor by one source pixel; emits is set when a result falls out
   task automatic downsample_pixel(input logic [PIX_W-1:0] pix, output bit emits,
                                   output mip_px_type res);
      int unsigned w, h, x, y, ox, ow, oh, oy;
      lane_quad_type px, pair;
      bit          pair_done, last_col, last_row;
      logic [LANE_W:0] s;
      w = dim_eff(width_cfg, MAX_WIDTH);
      h = dim_eff(height_cfg, MAX_HEIGHT);
      x = col_pos;
      y = row_pos;
      last_col = (x + 1 >= w);
      last_row = (y + 1 >= h);
      for (int i = 0; i < NUM_LANES; i++) px[i] = {1'b0, pix[8*i +: 8]};
      pair = '0;
      pair_done = 1'b0;
      ox = 0;
      emits = 1'b0;
      res = '0;

      // Pair up horizontal neighbours; a single column pairs with itself
      if (w == 1) begin
         for (int i = 0; i < NUM_LANES; i++) pair[i] = px[i] + px[i];
         pair_done = 1'b1;
      end else if (x % 2 == 1) begin
         for (int i = 0; i < NUM_LANES; i++) pair[i] = pair_acc[i] + px[i];
         pair_done = 1'b1;
         ox = x / 2;
      end else begin
         pair_acc = px;
      end

      // Advance the raster position, wrapping at the end of the level
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end

      if (!pair_done) return;
      ow = (w == 1) ? 1 : w / 2;
      oh = (h == 1) ? 1 : h / 2;
      oy = (h == 1) ? 0 : y / 2;

      if (h == 1) begin
         for (int i = 0; i < NUM_LANES; i++) res.dst_pixel[8*i +: 8] = 8'(pair[i] >> 1);
      end else if (y % 2 == 1) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            s = {1'b0, col_store[ox][i]} + {1'b0, pair[i]};
            res.dst_pixel[8*i +: 8] = s[LANE_W:2];
         end
      end else begin
         col_store[ox] = pair;
         return;
      end
      emits = 1'b1;
      res.row_end = (ox + 1 >= ow);
      res.frame_end = res.row_end && (oy + 1 >= oh);
   endtask

   task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] got,
                                input logic [PIX_W-1:0] want);
      err_count++;
      if (err_count <= 40)
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   // Write one register once every pending result has come back
   task automatic write_reg(input csr_reg_type sel, input logic [DIM_W-1:0] val);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_px.size() != 0);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (sel == REG_SOURCE_WIDTH) width_cfg = val;
      else height_cfg = val;
      col_pos = 0;
      row_pos = 0;
      pair_acc = '0;
   endtask

   // Offer one pixel, idling first at random; pause drains all results beforehand
   task automatic offer_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                              input mip_px_type want, input bit pause);
      int      gap;
      bit      emits;
      mip_px_type res;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0 || pause) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         if (pause) begin
            do @(posedge clock); while (pending_px.size() != 0);
         end
      end
      req_valid <= 1'b1;
      req_src_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      pixels_in++;
      downsample_pixel(pix, emits, res);
      if (typed) pending_px.push_back(want);
      else if (emits) pending_px.push_back(res);
   endtask

   // Set both dimensions, then stream n random pixels; hold stalls the receiver
   task automatic run_level(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input int n, input int hold);
      levels_run++;
      write_reg(REG_SOURCE_WIDTH, w);
      write_reg(REG_SOURCE_HEIGHT, h);
      hold_left = hold;
      for (int k = 0; k < n; k++)
         offer_pixel($urandom, 1'b0, '0, $urandom_range(0, 149) == 0);
   endtask

   // Result side: stall at random or for a counted hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      mip_px_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_px.size() == 0) begin
            flag_mismatch("unexpected result", rsp_dst_pixel, '0);
         end else begin
            want = pending_px.pop_front();
            results_checked++;
            if (rsp_dst_pixel !== want.dst_pixel)
               flag_mismatch("dst_pixel", rsp_dst_pixel, want.dst_pixel);
            if (rsp_row_end !== want.row_end)
               flag_mismatch("row_end", 32'(rsp_row_end), 32'(want.row_end));
            if (rsp_frame_end !== want.frame_end)
               flag_mismatch("frame_end", 32'(rsp_frame_end), 32'(want.frame_end));
         end
      end
   end

   initial begin
      mip_px_type       want;
      logic [DIM_W-1:0] w, h;
      int unsigned      ew, eh, frame;
      int               n, pick, rnd_start;
      err_count = 0;
      results_checked = 0;
      pixels_in = 0;
      levels_run = 0;
      hold_left = 0;
      width_cfg = WIDTH_RESET;
      height_cfg = HEIGHT_RESET;
      col_pos = 0;
      row_pos = 0;
      pair_acc = '0;
      send_idle_pct = 30;
      recv_idle_pct = 50;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (DIR_ROWS[k]) begin
         if (DIR_ROWS[k].is_csr) begin
            write_reg(DIR_ROWS[k].reg_sel, DIR_ROWS[k].dim);
         end else begin
            want.dst_pixel = DIR_ROWS[k].want_pixel;
            want.row_end = DIR_ROWS[k].want_row_end;
            want.frame_end = DIR_ROWS[k].want_frame_end;
            offer_pixel(DIR_ROWS[k].pixel, DIR_ROWS[k].typed, want, 1'b0);
         end
      end

      // Fill the block: one result per pixel while the receiver holds off
      run_level(13'd1, 13'd1, 60, 80);

      // Random levels, idling pattern changing by thirds
      rnd_start = pixels_in;
      while (pixels_in - rnd_start < RANDOM_PIXELS) begin
         if (pixels_in - rnd_start < RANDOM_PIXELS / 3) begin
            send_idle_pct = 30;
            recv_idle_pct = 50;
         end else if (pixels_in - rnd_start < 2 * RANDOM_PIXELS / 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 30;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            w = DIM_W'($urandom);
            h = DIM_W'($urandom_range(0, 6));
         end else if (pick == 1) begin
            w = DIM_W'($urandom_range(1, 6));
            h = DIM_W'($urandom);
         end else begin
            w = DIM_W'($urandom_range(0, 10));
            h = DIM_W'($urandom_range(0, 8));
         end
         ew = dim_eff(w, MAX_WIDTH);
         eh = dim_eff(h, MAX_HEIGHT);
         frame = ew * eh;
         // Whole levels when small, often with a partial row left over
         if (frame <= 160) n = frame * $urandom_range(1, 2) + $urandom_range(0, ew);
         else n = $urandom_range(20, 240);
         run_level(w, h, n, 0);
      end

      // Extreme settings: start of the widest row on a single line, tallest level,
      // both minimal
      run_level(13'd8191, 13'd0, 120, 0);
      run_level(13'd2, 13'd8191, 40, 0);
      run_level(13'd0, 13'd0, 30, 0);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_px.size() != 0);
      repeat (8) @(posedge clock);

      $display("run covered %0d pixels over %0d levels plus directed rows, %0d results checked",
               pixels_in, levels_run, results_checked);
      $display("sizes from 1x1 up to clamped 4096-pixel rows, with stalls on both sides");
      if (err_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
